[rtl/core/omfd_pkg.sv]
// Package for the object-record deframer: transaction types, codes and register map.
`timescale 1ns / 1ps
`default_nettype none

package omfd_pkg;

  // Configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-1:0] REG_ALLOW_ZERO_CSUM = 3'd0;

  // Record framing
  localparam int LEN_W = 16;

  typedef enum logic [1:0] {
    PH_TYPE   = 2'd0,
    PH_LEN_LO = 2'd1,
    PH_LEN_HI = 2'd2,
    PH_BODY   = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    ROLE_TYPE     = 3'd0,
    ROLE_LEN_LO   = 3'd1,
    ROLE_LEN_HI   = 3'd2,
    ROLE_BODY     = 3'd3,
    ROLE_CHECKSUM = 3'd4
  } role_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_CSUM_ERR  = 2'd1,
    STAT_TRUNCATED = 2'd2,
    STAT_HALTED    = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] byte_out;
    role_t      byte_role;
    logic [7:0] record_type;
    logic       wide_record;
    logic       record_end;
    status_t    status;
  } out_item_t;

endpackage

`default_nettype wire

[rtl/core/omf_record_deframer_core.sv]
// Object-record deframer top level: record parsing, checksum check, output skid stage.
//
// Usage:
//   Input channel (in_valid / in_stall / in_item) carries one stream byte per
//   transaction plus a mark on the final byte of the stream. Output channel
//   (out_valid / out_stall / out_item) returns one transaction per input byte:
//   the byte, its role in the record, the record type and its low bit, an
//   end-of-record mark and a status.
//   A result is registered in out_item, or in the skid entry while out_item waits.
//   Throughput: one byte per cycle while in_stall is low; the record state
//   (phase, length counter, 8-bit running sum) updates in one pass between the
//   input handshake and the result register.
//   Stall: a result held by out_stall stays put; the next byte still goes in
//   and lands in a one-entry skid register. in_stall rises only while that
//   skid entry is full, and it is a registered signal.
//   Reset (rst, synchronous): parser waits for a type byte, sum and length
//   clear, halt flag clears, allow_zero_checksum returns to 1, both output
//   entries empty.
//   After a checksum error or a truncated stream every later byte reports
//   status halted until reset.
//   Config: APB, register 0 at byte address 0 (allow_zero_checksum, bit 0);
//   write only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module omf_record_deframer_core
  import omfd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  // input byte channel
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire in_item_t           in_item,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_stall,
  output out_item_t               out_item,
  // APB configuration port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0]      prdata,
  output logic                    pready
);

  // ---------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------
  logic allow_zero_csum;
  logic cfg_wr;
  logic cfg_hit;

  assign pready  = 1'b1;
  assign cfg_hit = (paddr == REG_ALLOW_ZERO_CSUM);
  assign cfg_wr  = psel && penable && pwrite && pready && cfg_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      allow_zero_csum <= 1'b1;
    end else if (cfg_wr) begin
      allow_zero_csum <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (cfg_hit) begin
      prdata[0] = allow_zero_csum;
    end
  end

  // ---------------------------------------------------------------------------
  // Parser state
  // ---------------------------------------------------------------------------
  phase_t           phase, phase_next;
  logic [7:0]       current_type, current_type_next;
  logic [LEN_W-1:0] bytes_left, bytes_left_next;
  logic [7:0]       running_sum, running_sum_next;
  logic             halted, halted_next;

  logic      in_fire;
  logic      out_fire;
  out_item_t res;
  logic      skid_valid;
  out_item_t skid_item;

  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid && !out_stall;

  // shared decode used by both next-state and result logic
  logic [7:0] b;
  logic [7:0] sum_add;
  logic       at_csum;    // body byte that is the checksum
  logic       csum_bad;
  logic       rec_end;
  logic       err;        // checksum error or truncation on this byte

  always_comb begin
    b        = in_item.data_byte;
    sum_add  = running_sum + b;
    at_csum  = (phase == PH_BODY) && (bytes_left <= LEN_W'(1));
    // zero checksum byte means "unchecked" only when the register allows it
    csum_bad = at_csum && !((b == 8'd0) && allow_zero_csum) && (sum_add != 8'd0);
    rec_end  = at_csum || ((phase == PH_LEN_HI) && ({b, bytes_left[7:0]} == '0));
    err      = csum_bad || (in_item.last_byte && !rec_end);
  end

  // next state
  always_comb begin
    phase_next        = phase;
    current_type_next = current_type;
    bytes_left_next   = bytes_left;
    running_sum_next  = running_sum;
    halted_next       = halted;
    if (in_fire && !halted) begin
      halted_next = err;
      case (phase)
        PH_TYPE: begin
          current_type_next = b;
          running_sum_next  = b;
          phase_next        = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          bytes_left_next  = {8'd0, b};
          running_sum_next = sum_add;
          phase_next       = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          bytes_left_next  = {b, bytes_left[7:0]};
          running_sum_next = sum_add;
          phase_next       = rec_end ? PH_TYPE : PH_BODY;
        end
        PH_BODY: begin
          running_sum_next = sum_add;
          if (at_csum) begin
            bytes_left_next = '0;
            phase_next      = PH_TYPE;
          end else begin
            bytes_left_next = bytes_left - LEN_W'(1);
          end
        end
        default: begin
          phase_next = PH_TYPE;
        end
      endcase
    end
  end

  // result for the byte being accepted
  always_comb begin
    res.byte_out    = b;
    res.byte_role   = ROLE_TYPE;
    res.record_type = 8'd0;
    res.wide_record = 1'b0;
    res.record_end  = 1'b0;
    res.status      = STAT_HALTED;
    if (!halted) begin
      case (phase)
        PH_TYPE:   res.byte_role = ROLE_TYPE;
        PH_LEN_LO: res.byte_role = ROLE_LEN_LO;
        PH_LEN_HI: res.byte_role = ROLE_LEN_HI;
        PH_BODY:   res.byte_role = at_csum ? ROLE_CHECKSUM : ROLE_BODY;
        default:   res.byte_role = ROLE_TYPE;
      endcase
      res.record_type = (phase == PH_TYPE) ? b : current_type;
      res.wide_record = res.record_type[0];
      res.record_end  = rec_end;
      // checksum failure wins over truncation on the same byte
      if (csum_bad) begin
        res.status = STAT_CSUM_ERR;
      end else if (in_item.last_byte && !rec_end) begin
        res.status = STAT_TRUNCATED;
      end else begin
        res.status = STAT_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_TYPE;
      current_type <= 8'd0;
      bytes_left   <= '0;
      running_sum  <= 8'd0;
      halted       <= 1'b0;
    end else begin
      phase        <= phase_next;
      current_type <= current_type_next;
      bytes_left   <= bytes_left_next;
      running_sum  <= running_sum_next;
      halted       <= halted_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register with one-entry skid
  // ---------------------------------------------------------------------------
  assign in_stall = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid && (out_fire || !out_valid)) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else if (in_fire) begin
        if (out_valid && !out_fire) begin
          skid_valid <= 1'b1;
        end else begin
          out_valid <= 1'b1;
        end
      end else if (out_fire) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (skid_valid && (out_fire || !out_valid)) begin
      out_item <= skid_item;
    end else if (in_fire) begin
      if (out_valid && !out_fire) begin
        skid_item <= res;
      end else begin
        out_item <= res;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/omfd_checker.sv]
// Port-level checker for the object-record deframer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module omfd_checker
  import omfd_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_item
);

  // held result stays in place
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("held result changed");

  // halt is sticky: a delivered halted transaction is never followed by another status
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && (out_item.status == STAT_HALTED)
    |=> !out_valid || (out_item.status == STAT_HALTED))
    else $error("status left halted");

  // halted results carry only the byte
  a_halt_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_item.status == STAT_HALTED)
    |-> (out_item.byte_role == ROLE_TYPE) && (out_item.record_type == 8'd0)
        && !out_item.wide_record && !out_item.record_end)
    else $error("halted result has nonzero fields");

  // a checksum byte always closes its record; a truncation never does
  a_end_mark: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_item.byte_role == ROLE_CHECKSUM || out_item.status == STAT_TRUNCATED)
    |-> out_item.record_end == (out_item.byte_role == ROLE_CHECKSUM))
    else $error("record end mark wrong");

  // wide flag follows the type's low bit
  a_wide: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.wide_record == out_item.record_type[0])
    else $error("wide_record mismatch");

endmodule

bind omf_record_deframer_core omfd_checker u_omfd_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

`default_nettype wire
